// ----- src/stepper_speed_ramp_period_unit_assert.svh -----
`ifndef STEPPER_SPEED_RAMP_PERIOD_UNIT_ASSERT_SVH
`define STEPPER_SPEED_RAMP_PERIOD_UNIT_ASSERT_SVH
// implication checked at every edge outside reset
`define SSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define SSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/ssr_pkg.sv -----
package ssr_pkg;
  localparam int RELOAD_BITS = 23;
  localparam int SPEED_BITS = 12;
  localparam logic [RELOAD_BITS-1:0] RELOAD_MAX = 23'd8388607;
  localparam int TICKS_PER_US = 80;
  localparam logic [26:0] SPS_RECIP = 27'd71582789;

  localparam logic [2:0] FUNC_TICK = 3'd0;
  localparam logic [2:0] FUNC_TARGET = 3'd1;
  localparam logic [2:0] FUNC_DIR = 3'd2;
  localparam logic [2:0] FUNC_START = 3'd3;
  localparam logic [2:0] FUNC_STOP = 3'd4;
  localparam logic [2:0] FUNC_ESTOP = 3'd5;
  localparam logic [2:0] FUNC_EXPIRE = 3'd6;

  localparam logic [2:0] REG_SOFT = 3'd0;
  localparam logic [2:0] REG_ACCEL = 3'd1;
  localparam logic [2:0] REG_SPR = 3'd2;
  localparam logic [2:0] REG_MIN = 3'd3;
  localparam logic [2:0] REG_MAX = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RAMP, ST_RDIV, ST_SPS, ST_SDIV, ST_PDIV, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic ramp_load;
    logic ramp_apply;
    logic sps_load;
    logic period_load;
    logic period_apply;
    logic div_start;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic need_ramp;
    logic need_speed;
    logic div_busy;
  } stat_t;
endpackage

// ----- src/ssr_div.sv -----
module ssr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [31:0] den;
  logic [5:0]  count;
  logic [32:0] trial;

  assign trial = {rem[31:0], quotient[31]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'd32;
      rem <= '0;
      quotient <= dividend;
      den <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- src/ssr_ctrl.sv -----
module ssr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  input  ssr_pkg::stat_t  stat,
  output ssr_pkg::ctrl_t  ctrl
);
  ssr_pkg::state_t state;
  ssr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssr_pkg::ST_IDLE: begin
        if (in_valid) state_next = ssr_pkg::ST_RAMP;
      end
      ssr_pkg::ST_RAMP: begin
        if (stat.need_ramp) state_next = ssr_pkg::ST_RDIV;
        else if (stat.need_speed) state_next = ssr_pkg::ST_SPS;
        else state_next = ssr_pkg::ST_DONE;
      end
      ssr_pkg::ST_RDIV: begin
        if (!stat.div_busy) state_next = ssr_pkg::ST_SPS;
      end
      ssr_pkg::ST_SPS: state_next = ssr_pkg::ST_SDIV;
      ssr_pkg::ST_SDIV: state_next = ssr_pkg::ST_PDIV;
      ssr_pkg::ST_PDIV: begin
        if (!stat.div_busy) state_next = ssr_pkg::ST_DONE;
      end
      ssr_pkg::ST_DONE: state_next = ssr_pkg::ST_OUT;
      ssr_pkg::ST_OUT: begin
        if (!out_stall) state_next = ssr_pkg::ST_IDLE;
      end
      default: state_next = ssr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ssr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctrl.take = in_valid;
      end
      ssr_pkg::ST_RAMP: begin
        ctrl.ramp_load = stat.need_ramp;
        ctrl.div_start = stat.need_ramp;
      end
      ssr_pkg::ST_RDIV: ctrl.ramp_apply = !stat.div_busy;
      ssr_pkg::ST_SPS: ctrl.sps_load = 1'b1;
      ssr_pkg::ST_SDIV: begin
        ctrl.div_start = 1'b1;
        ctrl.period_load = 1'b1;
      end
      ssr_pkg::ST_PDIV: ctrl.period_apply = !stat.div_busy;
      ssr_pkg::ST_DONE: ctrl.out_load = 1'b1;
      ssr_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- src/ssr_dp.sv -----
module ssr_dp (
  input  logic            clk,
  input  logic            rst,
  input  ssr_pkg::ctrl_t  ctrl,
  output ssr_pkg::stat_t  stat,
  input  logic [2:0]      func,
  input  logic [15:0]     rpm_value,
  input  logic            soft_flag,
  input  logic            cw_flag,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output logic [22:0]     reload_ticks,
  output logic            driver_enable,
  output logic            dir_level,
  output logic            step_level,
  output logic            running_flag,
  output logic [11:0]     current_rpm
);
  logic        soft_en;
  logic [15:0] accel;
  logic [15:0] spr;
  logic [11:0] min_rpm;
  logic [11:0] max_rpm;
  logic        running, stopping, direction, enable_level, step_state;
  logic [11:0] cur_speed, target_speed, from_speed;
  logic [15:0] elapsed;
  logic [22:0] reload_value;
  logic        speed_dirty;
  logic        ramp_neg;
  logic        ramp_done;
  logic [27:0] ramp_prod;
  logic [27:0] prod_q;
  logic [52:0] sps_prod;
  logic [31:0] sps;
  logic [31:0] div_a, div_b, div_q;
  logic        div_busy;
  logic [12:0] diff;
  logic [11:0] diff_mag;
  logic [15:0] el_next;
  logic [27:0] speed_prod;
  logic [19:0] half_us;
  logic [27:0] ticks;
  logic signed [16:0] rv;

  assign diff = {1'b0, target_speed} - {1'b0, from_speed};
  assign diff_mag = diff[12] ? 12'(-diff) : diff[11:0];
  assign el_next = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
  assign speed_prod = 28'(cur_speed) * 28'(spr);
  // divide by 60: drop two bits, then multiply by the reciprocal of 15
  assign sps_prod = 53'(prod_q[27:2]) * 53'(ssr_pkg::SPS_RECIP);
  assign sps = 32'(sps_prod[52:30]);
  assign half_us = 20'(div_q >> 1);
  assign ticks = 28'(half_us < 20'd2 ? 20'd2 : half_us) * 28'(ssr_pkg::TICKS_PER_US);
  assign rv = 17'(signed'(rpm_value));

  ssr_div u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  always_comb begin
    div_a = 32'(ramp_prod);
    div_b = 32'(accel);
    if (ctrl.period_load) begin
      div_a = 32'd1000000;
      div_b = (sps == 32'd0) ? 32'd1 : sps;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.need_ramp = speed_dirty && !ramp_done;
  assign stat.need_speed = speed_dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_en <= 1'b1;
      accel <= 16'd1000;
      spr <= 16'd1600;
      min_rpm <= '0;
      max_rpm <= 12'd300;
      running <= 1'b0;
      stopping <= 1'b0;
      cur_speed <= '0;
      target_speed <= '0;
      from_speed <= '0;
      elapsed <= '0;
      reload_value <= ssr_pkg::RELOAD_MAX;
      direction <= 1'b0;
      enable_level <= 1'b0;
      step_state <= 1'b0;
      speed_dirty <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ssr_pkg::REG_SOFT: soft_en <= cfg_data[0];
          ssr_pkg::REG_ACCEL: accel <= cfg_data;
          ssr_pkg::REG_SPR: spr <= cfg_data;
          ssr_pkg::REG_MIN: min_rpm <= cfg_data[11:0];
          ssr_pkg::REG_MAX: max_rpm <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (ctrl.take) begin
        speed_dirty <= 1'b0;
        case (func)
          ssr_pkg::FUNC_TICK: begin
            if (running && soft_en) begin
              elapsed <= el_next;
              ramp_done <= (el_next >= accel);
              ramp_neg <= stopping ? 1'b1 : diff[12];
              ramp_prod <= 28'(stopping ? from_speed : diff_mag) * 28'(el_next);
              speed_dirty <= 1'b1;
              if (el_next >= accel) begin
                cur_speed <= stopping ? 12'd0 : target_speed;
              end
            end
          end
          ssr_pkg::FUNC_TARGET: begin
            if (rv < signed'(17'(min_rpm))) target_speed <= min_rpm;
            else if (rv > signed'(17'(max_rpm))) target_speed <= max_rpm;
            else target_speed <= rv[11:0];
          end
          ssr_pkg::FUNC_DIR: direction <= cw_flag;
          ssr_pkg::FUNC_START: begin
            if (target_speed != 12'd0) begin
              enable_level <= 1'b1;
              running <= 1'b1;
              stopping <= 1'b0;
              ramp_done <= 1'b1;
              speed_dirty <= 1'b1;
              if (soft_en) begin
                from_speed <= '0;
                elapsed <= '0;
                cur_speed <= '0;
              end else begin
                cur_speed <= target_speed;
              end
            end
          end
          ssr_pkg::FUNC_STOP: begin
            if (running) begin
              if (soft_flag && soft_en) begin
                stopping <= 1'b1;
                from_speed <= cur_speed;
                elapsed <= '0;
              end else begin
                running <= 1'b0;
                stopping <= 1'b0;
                enable_level <= 1'b0;
              end
            end
          end
          ssr_pkg::FUNC_ESTOP: begin
            running <= 1'b0;
            stopping <= 1'b0;
            enable_level <= 1'b0;
            cur_speed <= '0;
            target_speed <= '0;
            step_state <= 1'b0;
          end
          ssr_pkg::FUNC_EXPIRE: step_state <= ~step_state;
          default: ;
        endcase
      end
      if (ctrl.ramp_apply) begin
        if (ramp_neg) cur_speed <= from_speed - div_q[11:0];
        else cur_speed <= from_speed + div_q[11:0];
      end
      if (ctrl.sps_load) begin
        prod_q <= speed_prod;
      end
      if (ctrl.period_apply) begin
        reload_value <= (ticks > 28'(ssr_pkg::RELOAD_MAX)) ? ssr_pkg::RELOAD_MAX
                                                           : ticks[22:0];
      end
      if (ctrl.out_load) begin
        speed_dirty <= 1'b0;
        if (stopping && cur_speed == 12'd0 && speed_dirty) begin
          running <= 1'b0;
          stopping <= 1'b0;
          enable_level <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      reload_ticks <= reload_value;
      current_rpm <= cur_speed;
      dir_level <= direction;
      step_level <= step_state;
      driver_enable <= enable_level && !(stopping && cur_speed == 12'd0 && speed_dirty);
      running_flag <= running && !(stopping && cur_speed == 12'd0 && speed_dirty);
    end
  end
endmodule

// ----- src/stepper_speed_ramp_period_unit.sv -----
// An event with no speed update goes from the ramp state straight to done and output;
// when the speed changes, the new period takes one pass through the serial divider,
// and a ramp step first divides by the ramp time in another pass through the same divider.
// One item at a time: the next item can enter in the cycle after the result is taken.
// Reset (rst, synchronous): config registers at defaults, motor stopped, internal reload at maximum.
module stepper_speed_ramp_period_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [15:0] rpm_value,
  input  logic        soft_flag,
  input  logic        cw_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [22:0] reload_ticks,
  output logic        driver_enable,
  output logic        dir_level,
  output logic        step_level,
  output logic        running_flag,
  output logic [11:0] current_rpm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  ssr_pkg::ctrl_t ctrl;
  ssr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  ssr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .stat(stat), .ctrl(ctrl)
  );

  ssr_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat), .func(func),
    .rpm_value(rpm_value), .soft_flag(soft_flag), .cw_flag(cw_flag),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .reload_ticks(reload_ticks), .driver_enable(driver_enable),
    .dir_level(dir_level), .step_level(step_level),
    .running_flag(running_flag), .current_rpm(current_rpm)
  );

`include "stepper_speed_ramp_period_unit_assert.svh"
  `SSR_ASSERT_IMP(a_excl, out_valid, in_stall)
  `SSR_ASSERT_NEXT(a_take, ctrl.take, !out_valid)
  `SSR_ASSERT_IMP(a_run, out_valid && running_flag, driver_enable)
endmodule
